// ----- rtl/core/ffha_pkg.sv -----
package ffha_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_INIT    = 2'd0;
  localparam op_t OP_ALLOC   = 2'd1;
  localparam op_t OP_RELEASE = 2'd2;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_HEAP_BASE   = 2'd0;
  localparam cfg_idx_t CFG_HEAP_LENGTH = 2'd1;

  localparam int CfgLenW = 17;

endpackage

// ----- rtl/core/first_fit_heap_allocator_core.sv -----
// First-fit heap allocator with coalescing.
// Input channel: an op (init, allocate, release) is taken at a clock edge
// with start high and busy low. Fields: in_op, in_req_bytes, in_user_addr.
// Result channel: out_valid is high for one cycle with out_result_addr and
// out_ok; the receiver cannot stall, so each result is taken in that cycle.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 heap_base,
// 1 heap_length) and cfg_wdata; cfg_ready is always high.
// Block table: one synchronous RAM entry {start, free, size} per 4-byte unit,
// one read or one write a cycle. Allocate walks the blocks in order and
// writes a tail block on a split; release merges the next block, then walks
// the blocks before the freed one to merge a free predecessor; init clears
// the table first; trivial cases (zero request, not ready, unknown op) fail
// with no table access.
// Reset: a clearing pass over every table entry runs with busy high; config
// writes are still taken. No result is produced for the reset pass.
// ALIGN_BYTES must be a power of two; HEADER_BYTES a multiple of four.
module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 12,
  parameter int ALIGN_BYTES  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_req_bytes,
  input  logic [31:0] in_user_addr,
  output logic        out_valid,
  output logic [31:0] out_result_addr,
  output logic        out_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int UNITS  = HEAP_BYTES / 4;
  localparam int UNIT_W = $clog2(UNITS);
  localparam int SIZE_W = $clog2(HEAP_BYTES + 1);
  localparam int ENT_W  = SIZE_W + 2;
  localparam int OFF_W  = $clog2(2 * HEAP_BYTES + 64);
  localparam int NEED_W = 34;
  localparam int ALG    = $clog2(ALIGN_BYTES);
  localparam int LEN_W  = ffha_pkg::CfgLenW;

  localparam logic [OFF_W-1:0]  HDR_O   = OFF_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0]  HEAP_O  = OFF_W'(HEAP_BYTES);
  localparam logic [SIZE_W-1:0] HDR_S   = SIZE_W'(HEADER_BYTES);
  localparam logic [NEED_W-1:0] SPLIT_N = NEED_W'(HEADER_BYTES + ALIGN_BYTES);
  localparam logic [SIZE_W-1:0] MIN_LEN = SIZE_W'(HEADER_BYTES + ALIGN_BYTES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DONE, S_INIT_END,
    S_A_RD, S_A_CHK, S_A_WR2,
    S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_WK,
    S_F_PRD, S_F_PCHK, S_F_PWR2
  } state_t;

  state_t              state_r, state_nxt;
  logic                busy_r, busy_nxt;
  logic                ov_r, ov_nxt;
  logic                ok_r, ok_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic                ready_r, ready_nxt;
  logic                init_r, init_nxt;
  logic [UNIT_W:0]     clr_r, clr_nxt;
  logic [SIZE_W-1:0]   len_r, len_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [OFF_W-1:0]    p_r, p_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [NEED_W-1:0]   need_r, need_nxt;
  logic [31:0]         base_r;
  logic [LEN_W-1:0]    hlen_r;

  logic                wr_en, rd_en;
  logic [UNIT_W-1:0]   wr_addr, rd_addr;
  logic [ENT_W-1:0]    wr_data, rd_data;

  // Current entry fields from the RAM read register.
  logic                e_st, e_fr;
  logic [SIZE_W-1:0]   e_sz;
  logic [OFF_W-1:0]    e_after_off, e_after_p;
  logic [NEED_W-1:0]   e_szx;
  logic [32:0]         req_rnd;
  logic [31:0]         rel_off;
  logic [31:0]         len_min;

  assign e_st        = rd_data[ENT_W-1];
  assign e_fr        = rd_data[ENT_W-2];
  assign e_sz        = rd_data[SIZE_W-1:0];
  assign e_szx       = NEED_W'(e_sz);
  assign e_after_off = off_r + HDR_O + OFF_W'(e_sz);
  assign e_after_p   = p_r + HDR_O + OFF_W'(e_sz);
  assign req_rnd     = (33'(in_req_bytes) + 33'(ALIGN_BYTES - 1)) >> ALG << ALG;
  assign rel_off     = in_user_addr - base_r - 32'(HEADER_BYTES);
  assign len_min     = (32'(hlen_r) > 32'(HEAP_BYTES)) ? 32'(HEAP_BYTES) : 32'(hlen_r);

  ffha_mem #(.DEPTH(UNITS), .WIDTH(ENT_W)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    ov_nxt    = 1'b0;
    ok_nxt    = ok_r;
    addr_nxt  = addr_r;
    ready_nxt = ready_r;
    init_nxt  = init_r;
    clr_nxt   = clr_r;
    len_nxt   = len_r;
    off_nxt   = off_r;
    p_nxt     = p_r;
    size_nxt  = size_r;
    need_nxt  = need_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r[UNIT_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (UNIT_W+1)'(UNITS - 1)) begin
          if (init_r) begin
            state_nxt = S_INIT_END;
          end else begin
            state_nxt = S_IDLE;
            busy_nxt  = 1'b0;
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          busy_nxt  = 1'b1;
          ok_nxt    = 1'b0;
          addr_nxt  = '0;
          state_nxt = S_DONE;
          unique case (in_op)
            ffha_pkg::OP_INIT: begin
              ready_nxt = 1'b0;
              init_nxt  = 1'b1;
              clr_nxt   = '0;
              len_nxt   = SIZE_W'(len_min) & ~SIZE_W'(3);
              state_nxt = S_CLR;
            end
            ffha_pkg::OP_ALLOC: begin
              if (ready_r && in_req_bytes != 32'd0) begin
                need_nxt  = NEED_W'(req_rnd);
                off_nxt   = '0;
                state_nxt = S_A_RD;
              end
            end
            ffha_pkg::OP_RELEASE: begin
              if (in_user_addr == 32'd0) begin
                ok_nxt = 1'b1;
              end else if (ready_r && rel_off < 32'(HEAP_BYTES) &&
                           rel_off[1:0] == 2'd0) begin
                off_nxt   = OFF_W'(rel_off);
                state_nxt = S_F_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DONE: begin
        ov_nxt    = 1'b1;
        busy_nxt  = 1'b0;
        state_nxt = S_IDLE;
      end
      S_INIT_END: begin
        init_nxt = 1'b0;
        if (len_r >= MIN_LEN) begin
          wr_en     = 1'b1;
          wr_data   = {1'b1, 1'b1, len_r - HDR_S};
          ready_nxt = 1'b1;
          ok_nxt    = 1'b1;
        end
        state_nxt = S_DONE;
      end
      // Allocate walk: read a block, then decide.
      S_A_RD: begin
        rd_en     = 1'b1;
        rd_addr   = off_r[UNIT_W+1:2];
        state_nxt = S_A_CHK;
      end
      S_A_CHK: begin
        if (!e_st) begin
          state_nxt = S_DONE;
        end else if (e_fr && e_szx >= need_r) begin
          ok_nxt    = 1'b1;
          addr_nxt  = base_r + 32'(off_r) + 32'(HEADER_BYTES);
          state_nxt = S_DONE;
          if (e_szx >= need_r + SPLIT_N) begin
            // Split: tail block first, then shrink this one.
            wr_en     = 1'b1;
            wr_addr   = UNIT_W'((off_r + HDR_O + OFF_W'(need_r)) >> 2);
            wr_data   = {1'b1, 1'b1, e_sz - SIZE_W'(need_r) - HDR_S};
            size_nxt  = SIZE_W'(need_r);
            state_nxt = S_A_WR2;
          end else begin
            wr_en   = 1'b1;
            wr_addr = off_r[UNIT_W+1:2];
            wr_data = {1'b1, 1'b0, e_sz};
          end
        end else begin
          off_nxt = e_after_off;
          if (e_after_off >= HEAP_O) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_A_RD;
          end
        end
      end
      S_A_WR2: begin
        wr_en     = 1'b1;
        wr_addr   = off_r[UNIT_W+1:2];
        wr_data   = {1'b1, 1'b0, size_r};
        state_nxt = S_DONE;
      end
      // Release: check block, merge next, then find and merge previous.
      S_F_RD: begin
        rd_en     = 1'b1;
        rd_addr   = off_r[UNIT_W+1:2];
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (!e_st || e_fr) begin
          state_nxt = S_DONE;
        end else begin
          size_nxt = e_sz;
          p_nxt    = e_after_off;
          if (e_after_off < HEAP_O) begin
            state_nxt = S_F_NRD;
          end else begin
            state_nxt = S_F_WK;
          end
        end
      end
      S_F_NRD: begin
        rd_en     = 1'b1;
        rd_addr   = p_r[UNIT_W+1:2];
        state_nxt = S_F_NCHK;
      end
      S_F_NCHK: begin
        if (e_st && e_fr) begin
          size_nxt = size_r + HDR_S + e_sz;
          wr_en    = 1'b1;
          wr_addr  = p_r[UNIT_W+1:2];
        end
        state_nxt = S_F_WK;
      end
      S_F_WK: begin
        wr_en     = 1'b1;
        wr_addr   = off_r[UNIT_W+1:2];
        wr_data   = {1'b1, 1'b1, size_r};
        ok_nxt    = 1'b1;
        p_nxt     = '0;
        state_nxt = S_F_PRD;
      end
      S_F_PRD: begin
        rd_en     = 1'b1;
        rd_addr   = p_r[UNIT_W+1:2];
        state_nxt = S_F_PCHK;
      end
      S_F_PCHK: begin
        if (!e_st || p_r == off_r) begin
          state_nxt = S_DONE;
        end else if (e_after_p == off_r) begin
          state_nxt = S_DONE;
          if (e_fr) begin
            wr_en     = 1'b1;
            wr_addr   = p_r[UNIT_W+1:2];
            wr_data   = {1'b1, 1'b1, e_sz + HDR_S + size_r};
            state_nxt = S_F_PWR2;
          end
        end else begin
          p_nxt = e_after_p;
          if (e_after_p >= HEAP_O) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_F_PRD;
          end
        end
      end
      S_F_PWR2: begin
        wr_en     = 1'b1;
        wr_addr   = off_r[UNIT_W+1:2];
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      busy_r  <= 1'b1;
      ov_r    <= 1'b0;
      ready_r <= 1'b0;
      init_r  <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      ready_r <= ready_nxt;
      init_r  <= init_nxt;
      clr_r   <= clr_nxt;
    end
    ok_r   <= ok_nxt;
    addr_r <= addr_nxt;
    len_r  <= len_nxt;
    off_r  <= off_nxt;
    p_r    <= p_nxt;
    size_r <= size_nxt;
    need_r <= need_nxt;
  end

  // Config registers; always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      hlen_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
        base_r <= cfg_wdata;
      end else if (cfg_index == ffha_pkg::CFG_HEAP_LENGTH) begin
        hlen_r <= cfg_wdata[LEN_W-1:0];
      end
    end
  end

  assign cfg_ready       = 1'b1;
  assign busy            = busy_r;
  assign out_valid       = ov_r;
  assign out_ok          = ok_r;
  assign out_result_addr = addr_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted op did not raise busy");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_result_addr == 32'd0))
    else $error("address on failed op");

endmodule

// ----- rtl/core/ffha_mem.sv -----
module ffha_mem #(
  parameter int DEPTH = 16384,
  parameter int WIDTH = 19
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the first-fit heap allocator.
// The driver offers alloc / release / init transactions on the start/busy port,
// and the scoreboard predicts each result when its transaction is accepted.
// The monitor compares every out_valid strobe against the oldest prediction.
// The config port is written only while the core is idle.

typedef struct packed {
  logic [31:0] addr;
  logic        ok;
} heap_result_t;

class heap_scoreboard;
  localparam int unsigned HeapBytes = 65536;
  localparam int unsigned HdrBytes  = 12;
  localparam int unsigned Align     = 8;
  localparam int unsigned Units     = HeapBytes / 4;

  bit [31:0]   base;
  bit [16:0]   length;
  bit          ready;
  bit          start_m [Units];
  bit          free_m  [Units];
  int unsigned psize   [Units];
  heap_result_t pending[$];
  int          errors;

  function void write_reg(ffha_pkg::cfg_idx_t idx, logic [31:0] data);
    if (idx == ffha_pkg::CFG_HEAP_BASE) base = data;
    else if (idx == ffha_pkg::CFG_HEAP_LENGTH) length = data[16:0];
  endfunction

  function bit is_block(longint unsigned off);
    return off < HeapBytes && (off % 4) == 0 && start_m[off / 4];
  endfunction

  function longint unsigned next_of(longint unsigned off);
    return off + HdrBytes + psize[off / 4];
  endfunction

  function heap_result_t note(ffha_pkg::op_t op, logic [31:0] req, logic [31:0] ua);
    heap_result_t r;
    longint unsigned len, need, off, have, nx, p;
    r = '0;
    case (op)
      ffha_pkg::OP_INIT: begin
        for (int i = 0; i < Units; i++) begin
          start_m[i] = 0; free_m[i] = 0; psize[i] = 0;
        end
        ready = 0;
        len = 64'(length);
        if (len > HeapBytes) len = HeapBytes;
        len = len & ~64'd3;
        if (len >= HdrBytes + Align) begin
          psize[0] = 32'(len - HdrBytes);
          free_m[0] = 1; start_m[0] = 1;
          ready = 1; r.ok = 1'b1;
        end
      end
      ffha_pkg::OP_ALLOC: begin
        if (ready && req != 0) begin
          need = ((longint'(req) + Align - 1) / Align) * Align;
          off = 0;
          while (is_block(off)) begin
            have = 64'(psize[off / 4]);
            if (free_m[off / 4] && have >= need) begin
              if (have >= need + HdrBytes + Align) begin
                nx = (off + HdrBytes + need) / 4;
                psize[nx] = 32'(have - need - HdrBytes);
                free_m[nx] = 1; start_m[nx] = 1;
                psize[off / 4] = 32'(need);
              end
              free_m[off / 4] = 0;
              r.addr = 32'(base + off + HdrBytes);
              r.ok = 1'b1;
              break;
            end
            off = next_of(off);
          end
        end
      end
      ffha_pkg::OP_RELEASE: begin
        if (ua == 0) r.ok = 1'b1;
        else if (ready) begin
          off = 64'(32'(ua - base - HdrBytes));
          if (is_block(off) && !free_m[off / 4]) begin
            free_m[off / 4] = 1;
            nx = next_of(off);
            // merge forward first, then backward into the predecessor
            if (is_block(nx) && free_m[nx / 4]) begin
              psize[off / 4] += HdrBytes + psize[nx / 4];
              start_m[nx / 4] = 0; free_m[nx / 4] = 0;
            end
            p = 0;
            while (is_block(p) && p != off && next_of(p) != off) p = next_of(p);
            if (is_block(p) && p != off && free_m[p / 4]) begin
              psize[p / 4] += HdrBytes + psize[off / 4];
              start_m[off / 4] = 0; free_m[off / 4] = 0;
            end
            r.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    pending.push_back(r);
    return r;
  endfunction

  function void check(logic [31:0] addr, logic ok);
    heap_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result addr=%h ok=%b", $realtime, addr, ok);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (addr !== e.addr) begin
      $display("%0t: result_addr expected %h actual %h", $realtime, e.addr, addr);
      errors++;
    end
    if (ok !== e.ok) begin
      $display("%0t: ok expected %b actual %b", $realtime, e.ok, ok);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam ffha_pkg::op_t OP_UNUSED = 2'd3;
  localparam int  WdogLimit = 100000;  // > reset and init clearing passes

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_req_bytes;
  logic [31:0] in_user_addr;
  logic        out_valid;
  logic [31:0] out_result_addr;
  logic        out_ok;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  first_fit_heap_allocator_core uut (.*);

  heap_scoreboard sb = new();

  // offsets (addr - base) of blocks the prediction says are in use
  logic [31:0] live[$];
  bit          idle_on;
  int          stall_cnt;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result monitor: strobe lasts one cycle, sample at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_result_addr, out_ok);
  end

  // watchdog: cycles with no transaction of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cnt <= 0;
    else if (stall_cnt >= WdogLimit) begin
      $display("tb: done, errors");
      $finish;
    end else
      stall_cnt <= stall_cnt + 1;
  end

  // one transaction on the command port; called at a rising edge
  task automatic run_op(ffha_pkg::op_t op, logic [31:0] req, logic [31:0] ua);
    int gap;
    heap_result_t r;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_req_bytes <= req;
    in_user_addr <= ua;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    r = sb.note(op, req, ua);
    // keep the in-use list in step with the prediction
    if (op == ffha_pkg::OP_ALLOC && r.ok) live.push_back(r.addr - sb.base);
    if (op == ffha_pkg::OP_INIT) live.delete();
    if (op == ffha_pkg::OP_RELEASE && r.ok && ua != 0)
      foreach (live[i])
        if (live[i] == ua - sb.base) begin
          live.delete(i);
          break;
        end
  endtask

  task automatic alloc(logic [31:0] n);
    run_op(ffha_pkg::OP_ALLOC, n, $urandom);
  endtask

  task automatic release_at(logic [31:0] ua);
    run_op(ffha_pkg::OP_RELEASE, $urandom, ua);
  endtask

  // wait for all predicted results, then let the core settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    @(negedge clk);
    while (busy) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(ffha_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] live_addr();
    return sb.base + live[$urandom_range(0, live.size() - 1)];
  endfunction

  function automatic logic [31:0] rand_base();
    return {30'($urandom_range(0, 32'h3FFF_FFFF)), 2'b00};
  endfunction

  task automatic random_op();
    int sel;
    logic [31:0] n;
    sel = $urandom_range(0, 99);
    if (live.size() > 40 && sel < 50) sel = 60;
    if (sel < 50) begin
      if (sel < 2) n = 0;
      else if (sel < 4) n = $urandom;
      else if (sel < 9) n = $urandom_range(1, 4096);
      else n = $urandom_range(1, 128);
      alloc(n);
    end else if (sel < 85) begin
      if (live.size() != 0) release_at(live_addr());
      else alloc($urandom_range(1, 64));
    end else if (sel < 93) begin
      // bad releases: junk, off by a word, below the first user address
      case ($urandom_range(0, 2))
        0: release_at($urandom);
        1: release_at(live.size() != 0 ? live_addr() + 4 : sb.base + 16);
        default: release_at(sb.base + $urandom_range(0, 11));
      endcase
    end else if (sel < 96) release_at(32'd0);
    else if (sel < 98) run_op(OP_UNUSED, $urandom, $urandom);
    else alloc(sb.length - $urandom_range(0, 40));
  endtask

  task automatic phase(logic [31:0] base, logic [31:0] len, int n_items);
    drain();
    cfg_write(ffha_pkg::CFG_HEAP_BASE, base);
    cfg_write(ffha_pkg::CFG_HEAP_LENGTH, len);
    idle_on = $urandom_range(0, 3) != 0;
    run_op(ffha_pkg::OP_INIT, $urandom, $urandom);
    for (int i = 0; i < n_items; i++) begin
      if (i % 64 == 0) idle_on = $urandom_range(0, 3) != 0;
      random_op();
    end
  endtask

  initial begin
    logic [31:0] a0, a1, a2;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_op        = ffha_pkg::OP_INIT;
    in_req_bytes = '0;
    in_user_addr = '0;
    cfg_valid    = 1'b0;
    cfg_index    = ffha_pkg::CFG_HEAP_BASE;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: heap not ready, zero release, unknown op, zero length init
    alloc(32'd16);
    release_at(32'd0);
    release_at(32'd12);
    run_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_op(ffha_pkg::OP_INIT, '0, '0);
    drain();
    cfg_write(ffha_pkg::CFG_HEAP_LENGTH, 32'd19);   // rounds to 16: too small
    run_op(ffha_pkg::OP_INIT, '0, '0);
    drain();
    cfg_write(ffha_pkg::CFG_HEAP_LENGTH, 32'd65536);
    run_op(ffha_pkg::OP_INIT, '0, '0);
    alloc(32'd0);
    alloc(32'hFFFF_FFFF);
    alloc(32'hFFFF_FFF9);
    alloc(32'd65536);                     // no fit
    alloc(32'd1);
    a0 = sb.base + live[live.size() - 1];
    alloc(32'd9);
    a1 = sb.base + live[live.size() - 1];
    alloc(32'd8);
    a2 = sb.base + live[live.size() - 1];
    release_at(a1);                       // no neighbor free
    release_at(a1);                       // double release
    release_at(a0);                       // merges with next
    release_at(a2 + 4);                   // not a block start
    release_at(a2);                       // merges both sides
    alloc(32'd65524);                     // rounds up past the whole heap: no fit
    alloc(32'd1);
    release_at(32'd12);

    // random phases across base and length settings, extremes included
    phase(32'd0, 32'd65536, 380);
    phase(32'hFFFF_FFFC, 32'd65536, 280);
    phase(rand_base(), 32'd20, 80);
    phase(rand_base(), 32'd19, 30);
    phase(rand_base(), 32'd302, 150);
    // move the base under a live heap, no re-init
    drain();
    cfg_write(ffha_pkg::CFG_HEAP_BASE, rand_base());
    for (int i = 0; i < 150; i++) random_op();
    phase(rand_base(), 32'd4099, 280);
    phase(32'd0, 32'd0, 30);
    phase(32'h0001_0000, 32'd131071, 60); // over range: clamped

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
